// ===== rtl/mp2_pkg.sv =====
// Shared constants and types for the 2x2 stride-2 max pooling block.
package mp2_pkg;

  localparam int DEF_MAX_WIDTH   = 4096;
  localparam int DEF_SAMPLE_BITS = 16;

  // Configuration registers hold 13 bits each.
  localparam int CFG_BITS   = 13;
  localparam int MAX_ROWS   = 4096;
  localparam int MAX_PLANES = 4096;
  localparam int ROW_BITS   = 12;
  localparam int PLANE_BITS = 12;

  localparam logic [CFG_BITS-1:0] RST_WIDTH  = 13'd2;
  localparam logic [CFG_BITS-1:0] RST_HEIGHT = 13'd2;
  localparam logic [CFG_BITS-1:0] RST_COUNT  = 13'd1;

  typedef enum logic [1:0] {
    REG_PLANE_WIDTH  = 2'd0,
    REG_PLANE_HEIGHT = 2'd1,
    REG_PLANE_COUNT  = 2'd2,
    REG_NONE         = 2'd3
  } reg_idx_t;

  // Position flags that travel with a window toward the output.
  typedef struct packed {
    logic row_end;
    logic plane_end;
    logic frame_end;
  } pos_flags_t;

endpackage

// ===== rtl/max_pool_2x2_stride2.sv =====
// Top level of the 2x2 stride-2 max pooling block with its line store.
// A word that completes a window passes the line store read register, then the
// final compare into the output register. One input word per cycle is taken
// unless a stalled window holds the input; the single-port line store takes one
// write or one read per pixel pair in the window. Only odd rows of a plane
// produce output. Reset (rst_n low, synchronous) sets the registers to 2, 2, 1,
// clears the position counters and pipeline valids; the line store is not cleared.
module max_pool_2x2_stride2 #(
  parameter int MAX_WIDTH   = mp2_pkg::DEF_MAX_WIDTH,
  parameter int SAMPLE_BITS = mp2_pkg::DEF_SAMPLE_BITS,
  localparam int TDW = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic           clk,
  input  logic           rst_n,
  // input stream
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic [TDW-1:0] in_tdata,     // [SAMPLE_BITS-1:0] pixel, rest zero
  // output stream
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [TDW-1:0] out_tdata,    // [SAMPLE_BITS-1:0] pooled, rest zero
  output logic [1:0]     out_tuser,    // [0] row_end, [1] plane_end
  output logic           out_tlast,    // frame_end
  // configuration port
  input  logic           cfg_psel,
  input  logic           cfg_penable,
  input  logic           cfg_pwrite,
  input  logic [3:0]     cfg_paddr,
  input  logic [31:0]    cfg_pwdata,
  output logic [31:0]    cfg_prdata,
  output logic           cfg_pready
);

  localparam int CB         = mp2_pkg::CFG_BITS;
  localparam int CW         = $clog2(MAX_WIDTH);
  localparam int WB         = $clog2(MAX_WIDTH + 1);
  localparam int CMPW       = (WB > CB) ? WB : CB;
  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int AW         = $clog2(LINE_DEPTH);
  localparam int RB         = mp2_pkg::ROW_BITS;
  localparam int PB         = mp2_pkg::PLANE_BITS;

  // ---------------- configuration ----------------
  logic [CB-1:0] width_cfg_r, height_cfg_r, count_cfg_r;
  mp2_pkg::reg_idx_t cfg_idx;
  logic cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = mp2_pkg::reg_idx_t'(cfg_paddr[3:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_cfg_r  <= mp2_pkg::RST_WIDTH;
      height_cfg_r <= mp2_pkg::RST_HEIGHT;
      count_cfg_r  <= mp2_pkg::RST_COUNT;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        mp2_pkg::REG_PLANE_WIDTH:  width_cfg_r  <= cfg_pwdata[CB-1:0];
        mp2_pkg::REG_PLANE_HEIGHT: height_cfg_r <= cfg_pwdata[CB-1:0];
        mp2_pkg::REG_PLANE_COUNT:  count_cfg_r  <= cfg_pwdata[CB-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_prdata = '0;
    unique case (cfg_idx)
      mp2_pkg::REG_PLANE_WIDTH:  cfg_prdata = 32'(width_cfg_r);
      mp2_pkg::REG_PLANE_HEIGHT: cfg_prdata = 32'(height_cfg_r);
      mp2_pkg::REG_PLANE_COUNT:  cfg_prdata = 32'(count_cfg_r);
      default:                   cfg_prdata = '0;
    endcase
  end

  // Registers out of range saturate to their legal bounds.
  logic [CMPW-1:0] width_ext;
  logic [WB-1:0]   w_cl;
  logic [CB-1:0]   h_cl, p_cl;

  always_comb begin
    width_ext = CMPW'(width_cfg_r);
    if (width_ext < CMPW'(2))              w_cl = WB'(2);
    else if (width_ext > CMPW'(MAX_WIDTH)) w_cl = WB'(MAX_WIDTH);
    else                                   w_cl = WB'(width_ext);

    if (height_cfg_r < CB'(2))                      h_cl = CB'(2);
    else if (height_cfg_r > CB'(mp2_pkg::MAX_ROWS)) h_cl = CB'(mp2_pkg::MAX_ROWS);
    else                                            h_cl = height_cfg_r;

    if (count_cfg_r < CB'(1))                        p_cl = CB'(1);
    else if (count_cfg_r > CB'(mp2_pkg::MAX_PLANES)) p_cl = CB'(mp2_pkg::MAX_PLANES);
    else                                             p_cl = count_cfg_r;
  end

  // ---------------- position and first compare ----------------
  logic [CW-1:0] col_r, col_nxt;
  logic [RB-1:0] row_r, row_nxt;
  logic [PB-1:0] plane_r, plane_nxt;
  logic signed [SAMPLE_BITS-1:0] left_r, left_nxt;

  logic signed [SAMPLE_BITS-1:0] pixel, pair;
  logic in_acc, col_odd, in_win, wr_en, rd_en;
  logic col_last, row_last, plane_last;
  logic [AW-1:0] slot;
  mp2_pkg::pos_flags_t flags;

  assign pixel   = $signed(in_tdata[SAMPLE_BITS-1:0]);
  assign in_acc  = in_tvalid && in_tready;
  assign col_odd = col_r[0];
  assign pair    = (left_r > pixel) ? left_r : pixel;
  assign slot    = col_r[AW:1];

  assign in_win = (WB'(col_r) < {w_cl[WB-1:1], 1'b0}) &&
                  (CB'(row_r) < {h_cl[CB-1:1], 1'b0});
  assign wr_en  = in_acc && col_odd && in_win && !row_r[0];
  assign rd_en  = in_acc && col_odd && in_win && row_r[0];

  assign flags.row_end   = (WB-1)'(col_r >> 1) == (WB-1)'(w_cl[WB-1:1] - 1'b1);
  assign flags.plane_end = flags.row_end &&
                           ((RB-1)'(row_r >> 1) == (RB-1)'(h_cl[CB-1:1] - 1'b1));
  assign flags.frame_end = flags.plane_end && (CB'(plane_r) >= (p_cl - 1'b1));

  assign col_last   = ((WB+1)'(col_r) + 1'b1) >= (WB+1)'(w_cl);
  assign row_last   = (CB'(row_r) + 1'b1) >= h_cl;
  assign plane_last = (CB'(plane_r) + 1'b1) >= p_cl;

  always_comb begin
    col_nxt   = col_r;
    row_nxt   = row_r;
    plane_nxt = plane_r;
    left_nxt  = left_r;
    if (in_acc) begin
      if (!col_odd) left_nxt = pixel;
      if (col_last) begin
        col_nxt = '0;
        if (row_last) begin
          row_nxt   = '0;
          plane_nxt = plane_last ? '0 : plane_r + 1'b1;
        end else begin
          row_nxt = row_r + 1'b1;
        end
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      plane_r <= '0;
      left_r  <= '0;
    end else begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      plane_r <= plane_nxt;
      left_r  <= left_nxt;
    end
  end

  // ---------------- line store ----------------
  // Even rows write the pair maximum; odd rows read it back into a register.
  // A read and a write to one slot are at least a row apart, so no forwarding.
  logic [SAMPLE_BITS-1:0] line_mem [LINE_DEPTH];
  logic [SAMPLE_BITS-1:0] line_rd_r;

  always_ff @(posedge clk) begin
    if (wr_en) line_mem[slot] <= pair;
    if (rd_en) line_rd_r <= line_mem[slot];
  end

  // ---------------- window stage and output register ----------------
  logic s1_valid_r, s1_valid_nxt;
  logic signed [SAMPLE_BITS-1:0] s1_pair_r;
  mp2_pkg::pos_flags_t s1_flags_r;

  logic out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_BITS-1:0] out_pooled_r, best;
  mp2_pkg::pos_flags_t out_flags_r;

  logic out_adv, s1_adv;

  assign out_adv   = !out_valid_r || out_tready;
  assign s1_adv    = s1_valid_r && out_adv;
  // The read data register changes only on an accepted word, so a stalled
  // window keeps its line entry.
  assign in_tready = !s1_valid_r || out_adv;
  assign best      = ($signed(line_rd_r) > s1_pair_r) ? $signed(line_rd_r) : s1_pair_r;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (rd_en)       s1_valid_nxt = 1'b1;
    else if (s1_adv) s1_valid_nxt = 1'b0;

    out_valid_nxt = out_valid_r;
    if (s1_adv)          out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      s1_pair_r  <= pair;
      s1_flags_r <= flags;
    end
    if (s1_adv) begin
      out_pooled_r <= best;
      out_flags_r  <= s1_flags_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = TDW'(unsigned'(out_pooled_r));
  assign out_tuser  = {out_flags_r.plane_end, out_flags_r.row_end};
  assign out_tlast  = out_flags_r.frame_end;

endmodule

// ===== bench/pool_tracker_pkg.sv =====
// Predictor and result checker for the 2x2 stride-2 max pooling bench.
package pool_tracker_pkg;

  localparam int LINE_DEPTH = mp2_pkg::DEF_MAX_WIDTH / 2;

  typedef struct {
    logic signed [15:0] pooled;
    logic               row_end;
    logic               plane_end;
    logic               frame_end;
  } pooled_window_t;

  class window_max_tracker_t;
    logic [mp2_pkg::CFG_BITS-1:0] width_reg;
    logic [mp2_pkg::CFG_BITS-1:0] height_reg;
    logic [mp2_pkg::CFG_BITS-1:0] count_reg;
    logic signed [15:0]  pair_line [LINE_DEPTH];
    logic signed [15:0]  left_px;
    int unsigned         col_pos;
    int unsigned         row_pos;
    int unsigned         plane_pos;
    pooled_window_t      expected_windows [$];
    int unsigned         mismatches;
    int unsigned         windows_seen;

    function new();
      width_reg    = mp2_pkg::RST_WIDTH;
      height_reg   = mp2_pkg::RST_HEIGHT;
      count_reg    = mp2_pkg::RST_COUNT;
      foreach (pair_line[i]) pair_line[i] = '0;
      left_px      = '0;
      col_pos      = 0;
      row_pos      = 0;
      plane_pos    = 0;
      mismatches   = 0;
      windows_seen = 0;
    endfunction

    function int unsigned bounded(int unsigned v, int unsigned lo, int unsigned hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    function int unsigned eff_width();
      return bounded(width_reg, 2, mp2_pkg::DEF_MAX_WIDTH);
    endfunction

    function void set_reg(mp2_pkg::reg_idx_t idx, logic [mp2_pkg::CFG_BITS-1:0] value);
      case (idx)
        mp2_pkg::REG_PLANE_WIDTH: begin
          width_reg = value;
        end
        mp2_pkg::REG_PLANE_HEIGHT: begin
          height_reg = value;
        end
        mp2_pkg::REG_PLANE_COUNT: begin
          count_reg = value;
        end
        default: begin
        end
      endcase
    endfunction

    // Works out what one accepted pixel produces and moves the raster position on.
    function void take_pixel(logic signed [15:0] px);
      int unsigned    w;
      int unsigned    h;
      int unsigned    planes;
      int unsigned    out_w;
      int unsigned    out_h;
      int unsigned    slot;
      logic signed [15:0] pair;
      pooled_window_t win;
      w      = eff_width();
      h      = bounded(height_reg, 2, mp2_pkg::MAX_ROWS);
      planes = bounded(count_reg, 1, mp2_pkg::MAX_PLANES);
      out_w  = w / 2;
      out_h  = h / 2;
      if ((col_pos % 2) == 0) begin
        left_px = px;
      end else if (col_pos < 2 * out_w && row_pos < 2 * out_h) begin
        slot = (col_pos / 2) % LINE_DEPTH;
        pair = (left_px > px) ? left_px : px;
        if ((row_pos % 2) == 0) begin
          pair_line[slot] = pair;
        end else begin
          win.pooled    = (pair_line[slot] > pair) ? pair_line[slot] : pair;
          win.row_end   = (col_pos / 2) == out_w - 1;
          win.plane_end = win.row_end && (row_pos / 2) == out_h - 1;
          win.frame_end = win.plane_end && plane_pos >= planes - 1;
          expected_windows.push_back(win);
        end
      end
      // Counters compare with >= so a shrunken bound wraps on the next advance.
      if (col_pos + 1 >= w) begin
        col_pos = 0;
        if (row_pos + 1 >= h) begin
          row_pos   = 0;
          plane_pos = (plane_pos + 1 >= planes) ? 0 : plane_pos + 1;
        end else begin
          row_pos = row_pos + 1;
        end
      end else begin
        col_pos = col_pos + 1;
      end
    endfunction

    function void report(string what);
      mismatches++;
      if (mismatches <= 10) $display("%0t ns: %s", $time, what);
    endfunction

    function void match_window(logic [15:0] data, logic [1:0] user, logic last);
      pooled_window_t exp_win;
      windows_seen++;
      if (expected_windows.size() == 0) begin
        report($sformatf("unexpected word: pooled=%0d row/plane/frame=%b%b%b",
                         $signed(data), user[0], user[1], last));
        return;
      end
      exp_win = expected_windows.pop_front();
      if (data !== exp_win.pooled || user[0] !== exp_win.row_end ||
          user[1] !== exp_win.plane_end || last !== exp_win.frame_end) begin
        report($sformatf({"word %0d: expected pooled=%0d row/plane/frame=%b%b%b, ",
                          "got pooled=%0d row/plane/frame=%b%b%b"},
                         windows_seen, exp_win.pooled, exp_win.row_end,
                         exp_win.plane_end, exp_win.frame_end,
                         $signed(data), user[0], user[1], last));
      end
    endfunction
  endclass

endpackage

// ===== bench/tb.sv =====
// Top-level bench for the 2x2 stride-2 max pooling block.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PIPE_LATENCY = 2;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_ITEMS = 640;

  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        in_tvalid    = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata     = '0;     // [15:0] pixel
  logic        out_tvalid;
  logic        out_tready   = 1'b0;
  logic [15:0] out_tdata;             // [15:0] pooled
  logic [1:0]  out_tuser;             // [0] row_end, [1] plane_end
  logic        out_tlast;             // frame_end
  logic        cfg_psel     = 1'b0;
  logic        cfg_penable  = 1'b0;
  logic        cfg_pwrite   = 1'b0;
  logic [3:0]  cfg_paddr    = '0;
  logic [31:0] cfg_pwdata   = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  pool_tracker_pkg::window_max_tracker_t tracker;

  // 0: sender idles less than receiver, 1: the reverse, 2: no idling.
  int unsigned stall_mode    = 0;
  int unsigned hold_requests = 0;
  int unsigned holds_served  = 0;
  int unsigned hold_left     = 0;
  int unsigned pixels_sent   = 0;
  int unsigned random_items  = 0;
  int unsigned reg_writes    = 0;
  bit          tally_random  = 1'b0;

  max_pool_2x2_stride2 u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #10 clk = ~clk;

  // Receiver: random back-pressure, plus one long hold-off on request.
  always @(posedge clk) begin
    if (holds_served != hold_requests) begin
      holds_served = hold_requests;
      hold_left    = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= $urandom_range(0, 99) >=
                    (stall_mode == 0 ? 63 : stall_mode == 1 ? 38 : 0);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      tracker.match_window(out_tdata, out_tuser, out_tlast);
    end
  end

  function automatic logic [15:0] rand_pixel();
    logic [15:0] corner [5];
    corner = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0100};
    // Some draws from a small set so ties and extremes meet in one window.
    if ($urandom_range(0, 4) == 0) return corner[$urandom_range(0, 4)];
    return 16'($urandom_range(0, 65535));
  endfunction

  task automatic send_pixel(logic [15:0] px);
    while ($urandom_range(0, 99) < (stall_mode == 0 ? 38 : stall_mode == 1 ? 63 : 0)) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= px;
    do @(posedge clk); while (!in_tready);
    tracker.take_pixel(px);
    pixels_sent++;
    if (tally_random) random_items++;
  endtask

  task automatic send_rows(int unsigned rows);
    repeat (rows * tracker.eff_width()) send_pixel(rand_pixel());
  endtask

  // Registers change only with the block drained: nothing offered, nothing owed.
  task automatic write_reg(mp2_pkg::reg_idx_t idx, logic [mp2_pkg::CFG_BITS-1:0] value);
    in_tvalid <= 1'b0;
    while (tracker.expected_windows.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= 32'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    tracker.set_reg(idx, value);
    reg_writes++;
  endtask

  // A phase starts and ends on an even row at column zero, so an odd row never
  // reads a line entry that its even row did not write. The long output hold,
  // when asked for, starts once the registers are set so pixels keep coming.
  task automatic run_phase(int unsigned w, int unsigned h, int unsigned n, int unsigned rows,
                           bit hold_now);
    write_reg(mp2_pkg::REG_PLANE_WIDTH, mp2_pkg::CFG_BITS'(w));
    write_reg(mp2_pkg::REG_PLANE_HEIGHT, mp2_pkg::CFG_BITS'(h));
    write_reg(mp2_pkg::REG_PLANE_COUNT, mp2_pkg::CFG_BITS'(n));
    if (hold_now) hold_requests <= hold_requests + 1;
    send_rows(rows);
    while ((tracker.row_pos % 2) != 0) send_rows(1);
  endtask

  initial begin
    logic [15:0] directed [25];
    int unsigned w;
    int unsigned h;
    int unsigned n;
    int unsigned pick;
    bit          hold_asked;
    bit          hold_now;
    tracker    = new();
    hold_asked = 1'b0;
    // Four 2x2 planes: all minimum, then the maximum top-left, top-right, bottom-right.
    // Then one 3x3 plane whose odd last column and row must be ignored.
    directed = '{16'h8000, 16'h8000, 16'h8000, 16'h8000,
                 16'h7FFF, 16'hFFFF, 16'h0000, 16'h8000,
                 16'hFFFF, 16'd300,  16'hFED4, 16'h0000,
                 16'hFFFB, 16'hFFFA, 16'hFFF9, 16'hFFFC,
                 16'd1,    16'd2,    16'h7FFF,
                 16'd3,    16'hFFF7, 16'h7FFF,
                 16'h7FFF, 16'h7FFF, 16'h7FFF};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < 16; i++) send_pixel(directed[i]);
    write_reg(mp2_pkg::REG_PLANE_WIDTH, 13'd3);
    write_reg(mp2_pkg::REG_PLANE_HEIGHT, 13'd3);
    write_reg(mp2_pkg::REG_PLANE_COUNT, 13'd2);
    for (int i = 16; i < 25; i++) send_pixel(directed[i]);

    // Register extremes: a wide line, saturating values above and below range.
    run_phase(128, 2, 1, 2, 1'b0);
    run_phase(2, 8191, 8191, 40, 1'b0);
    run_phase(1, 0, 0, 6, 1'b0);

    tally_random = 1'b1;
    while (random_items < RANDOM_ITEMS) begin
      stall_mode <= (random_items < RANDOM_ITEMS / 3) ? 0 :
                    (random_items < 2 * RANDOM_ITEMS / 3) ? 1 : 2;
      hold_now = !hold_asked && random_items >= 3 * RANDOM_ITEMS / 4;
      if (hold_now) hold_asked = 1'b1;
      pick = $urandom_range(0, 19);
      w    = (pick == 0) ? $urandom_range(0, 1) : $urandom_range(2, 17);
      pick = $urandom_range(0, 19);
      h    = (pick == 0) ? $urandom_range(0, 1) : $urandom_range(2, 9);
      pick = $urandom_range(0, 19);
      n    = (pick == 0) ? 0 : (pick == 1) ? 8191 : $urandom_range(1, 4);
      run_phase(w, h, n, ((w < 2) ? 48 : (96 / w < 2 ? 2 : 96 / w)) + $urandom_range(0, 4),
                hold_now);
    end
    in_tvalid <= 1'b0;

    while (tracker.expected_windows.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 6) @(posedge clk);

    $display("Sent %0d pixels (%0d in random phases), %0d register writes, %0d windows.",
             pixels_sent, random_items, reg_writes, tracker.windows_seen);
    $display("Covered clamped settings, odd sizes, plane changes and a long stall; %0d bad.",
             tracker.mismatches);
    if (tracker.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
